/* rtl/sapq_pkg.sv */
package sapq_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int ENTRY_COUNT_W = 5;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] new_key;
  } ctrl_t;

endpackage

/* rtl/sorted_array_priority_queue.sv */
// Shift-register priority queue of DEPTH signed 32-bit keys, kept sorted
// ascending in a row of compare-and-shift cells. Issue a request by raising
// start with cmd (insert or remove smallest) and key; busy is never raised,
// so one request is taken every cycle. The result shows one cycle after the
// request with done high for exactly that cycle and must be captured then,
// since the receiver cannot stall it. All cells compare against the new key
// in parallel and shift by one place in the same cycle, whatever the fill
// level. Equal keys: a new key goes ahead of older equal keys. Insert when
// full and remove when empty leave the queue unchanged and report ok low.
// head_key reads zero when empty.
module sorted_array_priority_queue
  import sapq_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd,
  input  logic signed [KEY_W-1:0]         key,
  output logic                            done,
  output logic                            ok,
  output logic signed [KEY_W-1:0]         head_key,
  output logic        [ENTRY_COUNT_W-1:0] entry_count,
  output logic                            is_empty
);

  logic             accept;
  logic             full;
  logic             empty;
  ctrl_t            ctrl;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;

  logic signed [KEY_W-1:0] cell_key  [DEPTH];
  logic                    cell_keep [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (fill_count == CNT_W'(DEPTH));
  assign empty  = (fill_count == '0);

  // Decode the request into the cell broadcast
  assign ctrl.ins     = accept && (cmd == CMD_INSERT) && !full;
  assign ctrl.rem     = accept && (cmd == CMD_REMOVE) && !empty;
  assign ctrl.new_key = key;

  always_comb begin
    fill_count_next = fill_count;
    if (ctrl.ins) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (ctrl.rem) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] prev_key;
    logic                    prev_keep;
    logic signed [KEY_W-1:0] next_key;
    logic                    occ;

    assign occ = (CNT_W'(i) < fill_count);

    if (i == 0) begin : g_first
      assign prev_key  = key;
      assign prev_keep = 1'b1;
    end else begin : g_mid
      assign prev_key  = cell_key[i-1];
      assign prev_keep = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_body
      assign next_key = cell_key[i+1];
    end

    sapq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ),
      .prev_key  (prev_key),
      .prev_keep (prev_keep),
      .next_key  (next_key),
      .key       (cell_key[i]),
      .keep      (cell_keep[i])
    );
  end

  // Count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
      ok         <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      done       <= accept;
      ok         <= ctrl.ins || ctrl.rem;
    end
  end

  // Result view of the updated state
  assign head_key    = empty ? '0 : cell_key[0];
  assign entry_count = ENTRY_COUNT_W'(fill_count);
  assign is_empty    = empty;

endmodule

/* rtl/sapq_cell.sv */
module sapq_cell
  import sapq_pkg::*;
(
  input  logic                    clk,
  input  ctrl_t                   ctrl,
  input  logic                    occ,
  input  logic signed [KEY_W-1:0] prev_key,
  input  logic                    prev_keep,
  input  logic signed [KEY_W-1:0] next_key,
  output logic signed [KEY_W-1:0] key,
  output logic                    keep
);

  // Entry stays in place on insert when it sorts strictly ahead of the new key
  assign keep = occ && (key < ctrl.new_key);

  // Insert: keep, take the new key at the boundary, or shift up from below.
  // Remove: shift down from above.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        key <= prev_keep ? ctrl.new_key : prev_key;
      end
    end else if (ctrl.rem) begin
      key <= next_key;
    end
  end

endmodule

/* rtl/sapq_checker.sv */
module sapq_checker
  import sapq_pkg::*;
(
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            cmd,
  input logic                            done,
  input logic                            ok,
  input logic signed [KEY_W-1:0]         head_key,
  input logic        [ENTRY_COUNT_W-1:0] entry_count,
  input logic                            is_empty
);

  // Every accepted request gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("request without result");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  // Empty queue reads a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (head_key == '0))
    else $error("head_key not zero when empty");

  // Insert into a non-full queue succeeds and grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_INSERT) && (entry_count != ENTRY_COUNT_W'(DEPTH)))
      |=> (ok && (entry_count == $past(entry_count) + ENTRY_COUNT_W'(1))))
    else $error("insert did not add an entry");

  // Remove from an empty queue fails and keeps it empty
  a_remove_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_REMOVE) && is_empty) |=> (!ok && is_empty))
    else $error("remove on empty queue misreported");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (.*);
